// ===== hdl/cpu_cycle_cost_accumulator_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the cycle cost accumulator
// Shared concurrent assertion forms; they compile away when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef CPU_CYCLE_COST_ACCUMULATOR_DEFINES_SVH
`define CPU_CYCLE_COST_ACCUMULATOR_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CCA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define CCA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define CCA_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CCA_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== hdl/ccca_pkg.sv =====
// ----------------------------------------------------------------------------
// ccca_pkg
// Types, command codes and widths shared by the cycle cost accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package ccca_pkg;

    localparam int CLASS_CNT   = 8;
    localparam int CLS_IDX_W   = 3;
    localparam int DELTA_W     = 6;
    localparam int TOTAL_W     = 64;
    localparam int COUNT_W     = 32;
    localparam int CMD_W       = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 2;
    localparam int QUEUE_DEPTH = 2;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_CLASS_FIRST  = 5'd0;
    localparam logic [CMD_W-1:0] CMD_CLASS_LAST   = 5'd7;
    localparam logic [CMD_W-1:0] CMD_LD_IMM_DWORD = 5'd8;
    localparam logic [CMD_W-1:0] CMD_LD_IMM_WORD  = 5'd9;
    localparam logic [CMD_W-1:0] CMD_LD_IMM_BYTE  = 5'd10;
    localparam logic [CMD_W-1:0] CMD_LD_IMM_OFS   = 5'd11;
    localparam logic [CMD_W-1:0] CMD_LD_REG_OFS   = 5'd12;
    localparam logic [CMD_W-1:0] CMD_LD_MULTI     = 5'd13;
    localparam logic [CMD_W-1:0] CMD_ST_IMM_OFS   = 5'd14;
    localparam logic [CMD_W-1:0] CMD_ST_REG_OFS   = 5'd15;
    localparam logic [CMD_W-1:0] CMD_ST_MULTI     = 5'd16;
    localparam logic [CMD_W-1:0] CMD_MUL          = 5'd17;
    localparam logic [CMD_W-1:0] CMD_MUL_LONG     = 5'd18;
    localparam logic [CMD_W-1:0] CMD_BRANCH       = 5'd19;
    localparam logic [CMD_W-1:0] CMD_UNDEF        = 5'd20;
    localparam logic [CMD_W-1:0] CMD_SWAP         = 5'd21;
    localparam logic [CMD_W-1:0] CMD_SWI          = 5'd22;
    localparam logic [CMD_W-1:0] CMD_BKPT         = 5'd23;
    localparam logic [CMD_W-1:0] CMD_MSR          = 5'd24;
    localparam logic [CMD_W-1:0] CMD_MRS          = 5'd25;

    // Core generations.
    localparam logic [1:0] CORE_OLDEST   = 2'd0;
    localparam logic [1:0] CORE_MIDDLE   = 2'd1;
    localparam logic [1:0] CORE_ENHANCED = 2'd2;

    // Access sizes.
    localparam logic [1:0] SIZE_WORD  = 2'd2;
    localparam logic [1:0] SIZE_DWORD = 2'd3;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CORE_KIND = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_EN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_OP_EN     = 2'd2;

    localparam logic [4:0] PC_LOAD_COST = 5'd4;
    localparam logic [4:0] MAX_REGS     = 5'd16;

    // One classified event on its way from the front to the back.
    typedef struct packed {
        logic                       is_class;
        logic [CLS_IDX_W-1:0]       cls_idx;
        logic                       inc;
        logic signed [DELTA_W-1:0]  delta;
    } t_ccca_op;

endpackage

`default_nettype wire

// ===== hdl/ccca_front.sv =====
// ----------------------------------------------------------------------------
// ccca_front
// Holds the configuration and turns each input item into a class or cost op.
// ----------------------------------------------------------------------------
`default_nettype none

module ccca_front
    import ccca_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic                   i_target_is_pc,
    input  wire logic [1:0]             i_size_code,
    input  wire logic [4:0]             i_num_regs,
    input  wire logic                   i_list_has_pc,
    input  wire logic [31:0]            i_mul_operand,
    input  wire logic [31:0]            i_psr_fields,
    input  wire logic                   i_privileged,
    output t_ccca_op                    o_op
);

    logic [1:0] r_core_kind;
    logic       r_cycle_en;
    logic       r_op_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_core_kind <= CORE_OLDEST;
            r_cycle_en  <= 1'b1;
            r_op_en     <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_CORE_KIND: r_core_kind <= i_cfg_data[1:0];
                CFG_CYCLE_EN:  r_cycle_en  <= i_cfg_data[0];
                CFG_OP_EN:     r_op_en     <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    function automatic logic [4:0] load_cost(input logic [1:0] core, input logic pc,
                                             input logic slow);
        logic [4:0] c;
        if (pc)
            c = PC_LOAD_COST;
        else if (core == CORE_OLDEST)
            c = 5'd2;
        else
            c = slow ? 5'd1 : 5'd0;
        return c;
    endfunction

    logic [1:0] core;
    logic [4:0] rc_sat;
    logic [4:0] multi_rest;
    logic       oldest;
    logic       enhanced;
    logic       dword;
    logic [4:0] cost;

    assign core       = (r_core_kind > CORE_ENHANCED) ? CORE_ENHANCED : r_core_kind;
    assign oldest     = (core == CORE_OLDEST);
    assign enhanced   = (core == CORE_ENHANCED);
    assign dword      = (i_size_code == SIZE_DWORD);
    assign rc_sat     = (i_num_regs > MAX_REGS) ? MAX_REGS : i_num_regs;
    assign multi_rest = (rc_sat > 5'd1) ? rc_sat - 5'd1 : 5'd1;

    always_comb begin
        cost = 5'd0;
        unique case (i_cmd) inside
            CMD_LD_IMM_DWORD: cost = load_cost(core, i_target_is_pc, 1'b0);
            CMD_LD_IMM_WORD, CMD_LD_IMM_BYTE:
                cost = load_cost(core, i_target_is_pc, 1'b1);
            CMD_LD_IMM_OFS:
                cost = load_cost(core, i_target_is_pc, i_size_code != SIZE_WORD);
            CMD_LD_REG_OFS: begin
                cost = load_cost(core, i_target_is_pc, i_size_code != SIZE_WORD)
                       + {4'd0, enhanced};
            end
            CMD_LD_MULTI: begin
                if (oldest)
                    cost = rc_sat + 5'd1 + (i_list_has_pc ? 5'd2 : 5'd0);
                else if (i_list_has_pc)
                    cost = multi_rest + ((enhanced && rc_sat == 5'd0) ? 5'd3 : 5'd4);
                else
                    cost = multi_rest;
            end
            CMD_ST_IMM_OFS: cost = {4'd0, oldest} + {4'd0, dword};
            CMD_ST_REG_OFS: cost = {4'd0, oldest || enhanced} + {4'd0, dword};
            CMD_ST_MULTI:   cost = oldest ? rc_sat : multi_rest;
            CMD_MUL: begin
                // Early termination on the significant bytes of the operand.
                if (enhanced)
                    cost = 5'd1;
                else if (~|i_mul_operand[31:8] || &i_mul_operand[31:8])
                    cost = 5'd1;
                else if (~|i_mul_operand[31:16] || &i_mul_operand[31:16])
                    cost = 5'd2;
                else if (~|i_mul_operand[31:24] || &i_mul_operand[31:24])
                    cost = 5'd3;
                else
                    cost = 5'd0;
            end
            CMD_MUL_LONG: begin
                if (enhanced || ~|i_mul_operand[31:8])
                    cost = 5'd2;
                else if (~|i_mul_operand[31:16])
                    cost = 5'd3;
                else if (~|i_mul_operand[31:24])
                    cost = 5'd4;
                else
                    cost = 5'd0;
            end
            CMD_BRANCH, CMD_SWI, CMD_BKPT: cost = 5'd2;
            CMD_UNDEF: cost = oldest ? 5'd3 : 5'd2;
            CMD_SWAP:  cost = oldest ? 5'd3 : 5'd1;
            // Unprivileged writes only reach the flag fields.
            CMD_MSR:   cost = (i_privileged && |i_psr_fields[23:0]) ? 5'd2 : 5'd0;
            CMD_MRS:   cost = oldest ? 5'd0 : 5'd1;
            default:   cost = 5'd0;
        endcase
    end

    always_comb begin
        o_op.is_class = (i_cmd <= CMD_CLASS_LAST);
        o_op.cls_idx  = i_cmd[CLS_IDX_W-1:0];
        o_op.inc      = r_op_en;
        o_op.delta    = (r_cycle_en && !o_op.is_class) ? signed'({1'b0, cost})
                                                       : '0;
    end

endmodule

`default_nettype wire

// ===== hdl/ccca_fifo.sv =====
// ----------------------------------------------------------------------------
// ccca_fifo
// Short register queue of classified ops between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_cycle_cost_accumulator_defines.svh"

module ccca_fifo
    import ccca_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_ccca_op i_push_op,
    output logic          o_full,
    output logic          o_valid,
    output t_ccca_op      o_head,
    input  wire logic     i_pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_ccca_op         r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic [CNT_W-1:0] n_count;
    logic             push;
    logic             pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_head  = r_mem[r_rd];
    assign push    = i_push && !o_full;
    assign pop     = i_pop && o_valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push)
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        if (pop)
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        if (push && !pop)
            n_count = r_count + 1'b1;
        else if (pop && !push)
            n_count = r_count - 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push)
            r_mem[r_wr] <= i_push_op;
    end

    `CCA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH))
    `CCA_ASSERT_IMP(a_empty_ptrs, i_clk, i_rst_n, r_count == '0, r_wr == r_rd)
    `CCA_ASSERT_NXT(a_fill_step, i_clk, i_rst_n, push && !pop, r_count == $past(r_count) + 1'b1)

endmodule

`default_nettype wire

// ===== hdl/ccca_back.sv =====
// ----------------------------------------------------------------------------
// ccca_back
// Applies queued ops to the class counters and the cycle total; output stage.
// ----------------------------------------------------------------------------
`default_nettype none

`include "cpu_cycle_cost_accumulator_defines.svh"

module ccca_back
    import ccca_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_op_valid,
    input  wire t_ccca_op               i_op,
    output logic                        o_pop,
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [DELTA_W-1:0]   o_cycle_delta,
    output logic [TOTAL_W-1:0]          o_cycle_total,
    output logic [COUNT_W-1:0]          o_class_count
);

    logic [TOTAL_W-1:0]        r_acc;
    logic [COUNT_W-1:0]        r_cnt [CLASS_CNT];
    logic                      r_out_valid;
    logic signed [DELTA_W-1:0] r_delta;
    logic [TOTAL_W-1:0]        r_total;
    logic [COUNT_W-1:0]        r_class;
    logic [TOTAL_W-1:0]        n_acc;
    logic [COUNT_W-1:0]        n_cnt;
    logic                      pop;

    assign pop   = i_op_valid && (!r_out_valid || i_out_ready);
    assign o_pop = pop;
    assign n_acc = r_acc + {{(TOTAL_W - DELTA_W){i_op.delta[DELTA_W-1]}}, i_op.delta};
    assign n_cnt = r_cnt[i_op.cls_idx] + {{(COUNT_W - 1){1'b0}}, i_op.inc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_out_valid <= 1'b0;
            for (int i = 0; i < CLASS_CNT; i++)
                r_cnt[i] <= '0;
        end else begin
            if (pop)
                r_out_valid <= 1'b1;
            else if (i_out_ready)
                r_out_valid <= 1'b0;
            if (pop && i_op.is_class)
                r_cnt[i_op.cls_idx] <= n_cnt;
            if (pop && !i_op.is_class)
                r_acc <= n_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            if (i_op.is_class) begin
                r_delta <= '0;
                r_total <= r_acc;
                r_class <= n_cnt;
            end else begin
                r_delta <= i_op.delta;
                r_total <= n_acc;
                r_class <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_cycle_delta = r_delta;
    assign o_cycle_total = r_total;
    assign o_class_count = r_class;

    `CCA_ASSERT_NXT(a_class_no_delta, i_clk, i_rst_n, pop && i_op.is_class, r_out_valid && ~|r_delta)
    `CCA_ASSERT_NXT(a_acc_hold, i_clk, i_rst_n, !pop, $stable(r_acc))
    `CCA_ASSERT_IMP(a_no_overrun, i_clk, i_rst_n, r_out_valid && !i_out_ready, !pop)

endmodule

`default_nettype wire

// ===== hdl/cpu_cycle_cost_accumulator.sv =====
// ----------------------------------------------------------------------------
// cpu_cycle_cost_accumulator
// Counts micro-op classes and accumulates per-core extra cycle costs.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) takes one micro-op event per item.
//   Commands 0 to 7 bump one of eight wrapping 32-bit class counters; commands
//   8 to 25 add the extra cycles of one operation kind to a wrapping 64-bit
//   total. Every item produces exactly one result item on the output channel
//   (o_out_valid / i_out_ready) with the delta, the running total and the
//   touched class count.
//   Configuration (i_cfg_valid / o_cfg_ready, always ready) selects the core
//   generation and enables cycle and class counting; write it only while idle.
//   The back registers each result. Throughput: one item per cycle,
//   sustained while the receiver is ready; the front classifies and costs an
//   item combinationally, and the single 64-bit add in the back sets the pace.
//   When the receiver stalls, results wait in the output register and the
//   two-entry queue fills; o_in_ready drops only once the queue is full.
//   Synchronous active-low reset clears all counters, the total, the queue,
//   and sets core kind 0 with both enables on.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu_cycle_cost_accumulator
    import ccca_pkg::*;
#(
    parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  i_cfg_data,
    // Input item channel.
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire logic [CMD_W-1:0]       i_cmd,
    input  wire logic                   i_target_is_pc,
    input  wire logic [1:0]             i_size_code,
    input  wire logic [4:0]             i_num_regs,
    input  wire logic                   i_list_has_pc,
    input  wire logic [31:0]            i_mul_operand,
    input  wire logic [31:0]            i_psr_fields,
    input  wire logic                   i_privileged,
    // Result item channel.
    output logic                        o_out_valid,
    input  wire logic                   i_out_ready,
    output logic signed [DELTA_W-1:0]   o_cycle_delta,
    output logic [TOTAL_W-1:0]          o_cycle_total,
    output logic [COUNT_W-1:0]          o_class_count
);

    t_ccca_op front_op;
    t_ccca_op head_op;
    logic     q_full;
    logic     q_valid;
    logic     q_pop;

    // Register writes are always accepted.
    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !q_full;

    // Front: configuration registers, decode and cost lookup.
    ccca_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (i_cmd),
        .i_target_is_pc (i_target_is_pc),
        .i_size_code    (i_size_code),
        .i_num_regs     (i_num_regs),
        .i_list_has_pc  (i_list_has_pc),
        .i_mul_operand  (i_mul_operand),
        .i_psr_fields   (i_psr_fields),
        .i_privileged   (i_privileged),
        .o_op           (front_op)
    );

    // Queue decouples the accepting side from a stalled receiver.
    ccca_fifo #(
        .DEPTH (QUEUE_DEPTH_P)
    ) u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (i_in_valid),
        .i_push_op (front_op),
        .o_full    (q_full),
        .o_valid   (q_valid),
        .o_head    (head_op),
        .i_pop     (q_pop)
    );

    // Back: counter and accumulator state plus the output register.
    ccca_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_op_valid    (q_valid),
        .i_op          (head_op),
        .o_pop         (q_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_cycle_delta (o_cycle_delta),
        .o_cycle_total (o_cycle_total),
        .o_class_count (o_class_count)
    );

endmodule

`default_nettype wire
